[rtl/core/pat_pkg.sv]
// ----------------------------------------------------------------------------
// pat_pkg: shared types, codes and helpers for the pending ack timeout table
// Holds table geometry, command and event codes, the controller/datapath
// command and status bundles, and small slot search and time helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pat_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int MAX_RESULTS = 16;
    localparam int MARK_W      = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int PERIOD_W = 10;
    localparam int ID_W     = 16;
    localparam int TMO_W    = 16;
    localparam int TAG_W    = 32;
    localparam int DATA_W   = 32;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 3;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(50);

    // Input commands
    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_RESPONSE = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;
    localparam logic [1:0] CMD_TICK     = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] EV_ADDED          = 3'd0;
    localparam logic [KIND_W-1:0] EV_FULL           = 3'd1;
    localparam logic [KIND_W-1:0] EV_DELIVERED      = 3'd2;
    localparam logic [KIND_W-1:0] EV_LATE           = 3'd3;
    localparam logic [KIND_W-1:0] EV_UNKNOWN        = 3'd4;
    localparam logic [KIND_W-1:0] EV_CANCELLED      = 3'd5;
    localparam logic [KIND_W-1:0] EV_CANCEL_UNKNOWN = 3'd6;
    localparam logic [KIND_W-1:0] EV_TIMEOUT        = 3'd7;

    // One table entry as stored in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]   key;
        logic [TIME_W-1:0] deadline;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture input item, update clock and sweep counter
        logic scan_step;  // read the next slot of the scan
        logic act;        // finish add, response or cancel, load one event
        logic emit_rd;    // read the lowest marked slot
        logic emit;       // load one timeout event, free the slot
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_tick;     // item at the input is a tick
        logic sweep_due;   // a tick accepted now starts a sweep
        logic cur_tick;    // item in work is a tick
        logic scan_last;   // scan reads the final slot
        logic mask_empty;  // no expired slot left to report
        logic emit_last;   // timeout being loaded is the final one
        logic out_free;    // output register can take an event
    } t_dp_stat;

    // Lowest set bit of a slot mask
    function automatic logic [IDX_W-1:0] lowest_index(input logic [TABLE_DEPTH-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // Late when now is strictly past the deadline, modulo 2^32
    function automatic logic is_late(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return (diff != '0) && !diff[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

[rtl/core/pat_ctrl.sv]
// ----------------------------------------------------------------------------
// pat_ctrl: sequencer of the pending ack timeout table
// Accepts one item at a time; bar a tick with no sweep, runs the slot scan,
// then finishes the command or walks the marked slots, one timeout event per visit.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_ctrl import pat_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_ACT,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // Decode commands and next state
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_stat.in_tick || i_stat.sweep_due) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = i_stat.cur_tick ? S_EMIT_RD : S_ACT;
            end
            S_ACT: begin
                if (i_stat.out_free) begin
                    o_cmd.act = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_EMIT_RD: begin
                if (i_stat.mask_empty) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A command item or a due tick always starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (!i_stat.in_tick || i_stat.sweep_due)) |=> r_state == S_SCAN)
        else $error("accepted item did not start a scan");

    // A tick that is not due finishes at once
    a_tick_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_stat.in_tick && !i_stat.sweep_due) |=> r_state == S_IDLE)
        else $error("tick without sweep did not return to idle");

    // A timeout read only follows a non-empty mark set
    a_emit_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_rd |=> (r_state == S_EMIT) && !i_stat.mask_empty)
        else $error("timeout read with no marked slot");

endmodule

`default_nettype wire

[rtl/core/pat_dp.sv]
// ----------------------------------------------------------------------------
// pat_dp: datapath of the pending ack timeout table
// Entry memory with one registered read port, valid flags, millisecond clock,
// sweep counter, scan compare stage, timeout mark set and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pat_dp import pat_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    // input item
    input  wire logic [1:0]          i_command,
    input  wire logic [ID_W-1:0]     i_ack_id,
    input  wire logic [TMO_W-1:0]    i_timeout_ms,
    input  wire logic [TAG_W-1:0]    i_user_tag,
    input  wire logic [DATA_W-1:0]   i_response_data,
    // result item
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [KIND_W-1:0]        o_event_kind,
    output logic [ID_W-1:0]          o_event_id,
    output logic [TAG_W-1:0]         o_event_tag,
    output logic [DATA_W-1:0]        o_event_data,
    output logic                     o_last,
    // controller
    input  wire t_ctrl_cmd           i_cmd,
    output t_dp_stat                 o_stat
);

    // Configuration and time state
    logic [PERIOD_W-1:0]    r_period;
    logic [TIME_W-1:0]      r_now;
    logic [PERIOD_W-1:0]    r_sweep;
    logic [TABLE_DEPTH-1:0] r_valid;

    // Captured item
    logic [1:0]        r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [TMO_W-1:0]  r_tmo;
    logic [TAG_W-1:0]  r_tag;
    logic [DATA_W-1:0] r_data;

    // Entry memory and read port
    t_entry           r_mem [TABLE_DEPTH];
    t_entry           r_rd_data;
    logic [IDX_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    // Scan results
    logic                   r_hit;
    logic [IDX_W-1:0]       r_hit_idx;
    logic [TAG_W-1:0]       r_hit_tag;
    logic                   r_hit_late;
    logic [TABLE_DEPTH-1:0] r_mask;
    logic [MARK_W-1:0]      r_mark_cnt;
    logic [IDX_W-1:0]       r_emit_idx;

    // Output register
    logic              r_o_valid;
    logic [KIND_W-1:0] r_o_kind;
    logic [ID_W-1:0]   r_o_id;
    logic [TAG_W-1:0]  r_o_tag;
    logic [DATA_W-1:0] r_o_data;
    logic              r_o_last;

    // Combinational helpers
    logic [PERIOD_W-1:0]    sweep_inc;
    logic                   any_valid;
    logic                   free_found;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       add_idx;
    logic                   add_ok;
    logic [IDX_W-1:0]       rd_addr;
    logic                   rd_en;
    logic                   wr_en;
    logic                   slot_valid;
    logic                   slot_late;
    logic [TABLE_DEPTH-1:0] hit_bit;
    logic [TABLE_DEPTH-1:0] emit_bit;
    logic [TABLE_DEPTH-1:0] mask_rest;
    logic                   out_free;
    logic                   out_load;
    logic [KIND_W-1:0]      n_kind;
    logic [ID_W-1:0]        n_id;
    logic [TAG_W-1:0]       n_tag;
    logic [DATA_W-1:0]      n_data;
    logic                   n_last;

    assign sweep_inc  = r_sweep + PERIOD_W'(1);
    assign any_valid  = |r_valid;
    assign free_found = ~&r_valid;
    assign free_idx   = lowest_index(~r_valid);
    assign add_idx    = r_hit ? r_hit_idx : free_idx;
    assign add_ok     = r_hit || free_found;
    assign rd_addr    = i_cmd.scan_step ? r_cnt : lowest_index(r_mask);
    assign rd_en      = i_cmd.scan_step || i_cmd.emit_rd;
    assign wr_en      = i_cmd.act && (r_cmd == CMD_ADD) && add_ok;
    assign slot_valid = r_valid[r_rd_idx];
    assign slot_late  = is_late(r_now, r_rd_data.deadline);
    assign hit_bit    = r_hit ? (TABLE_DEPTH'(1) << r_hit_idx) : '0;
    assign emit_bit   = TABLE_DEPTH'(1) << r_emit_idx;
    assign mask_rest  = r_mask & ~emit_bit;
    assign out_free   = !r_o_valid || i_ready;

    // Status to the controller
    always_comb begin
        o_stat.in_tick    = (i_command == CMD_TICK);
        o_stat.sweep_due  = any_valid && (sweep_inc >= r_period);
        o_stat.cur_tick   = (r_cmd == CMD_TICK);
        o_stat.scan_last  = (r_cnt == IDX_W'(TABLE_DEPTH - 1));
        o_stat.mask_empty = (r_mask == '0);
        o_stat.emit_last  = (mask_rest == '0);
        o_stat.out_free   = out_free;
    end

    // Build the next event
    always_comb begin
        out_load = 1'b0;
        n_kind   = EV_ADDED;
        n_id     = r_id;
        n_tag    = '0;
        n_data   = '0;
        n_last   = 1'b1;
        if (i_cmd.emit) begin
            out_load = 1'b1;
            n_kind   = EV_TIMEOUT;
            n_id     = r_rd_data.key;
            n_tag    = r_rd_data.tag;
            n_last   = (mask_rest == '0);
        end else if (i_cmd.act) begin
            out_load = 1'b1;
            unique case (r_cmd)
                CMD_ADD: begin
                    n_kind = add_ok ? EV_ADDED : EV_FULL;
                    n_tag  = add_ok ? r_tag : '0;
                end
                CMD_RESPONSE: begin
                    if (!r_hit) begin
                        n_kind = EV_UNKNOWN;
                    end else if (r_hit_late) begin
                        n_kind = EV_LATE;
                        n_tag  = r_hit_tag;
                    end else begin
                        n_kind = EV_DELIVERED;
                        n_tag  = r_hit_tag;
                        n_data = r_data;
                    end
                end
                CMD_CANCEL: begin
                    n_kind = r_hit ? EV_CANCELLED : EV_CANCEL_UNKNOWN;
                    n_tag  = r_hit ? r_hit_tag : '0;
                end
                CMD_TICK: begin
                    out_load = 1'b0;
                end
                default: begin
                    out_load = 1'b0;
                end
            endcase
        end
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[add_idx] <= '{key: r_id, deadline: r_now + TIME_W'(r_tmo), tag: r_tag};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Capture item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_command;
            r_id   <= i_ack_id;
            r_tmo  <= i_timeout_ms;
            r_tag  <= i_user_tag;
            r_data <= i_response_data;
        end
        if (i_cmd.emit_rd) begin
            r_emit_idx <= rd_addr;
        end
        if (r_rd_vld && slot_valid && (r_rd_data.key == r_id) && !r_hit) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_tag  <= r_rd_data.tag;
            r_hit_late <= slot_late;
        end
        r_rd_idx <= r_cnt;
        if (out_load) begin
            r_o_kind <= n_kind;
            r_o_id   <= n_id;
            r_o_tag  <= n_tag;
            r_o_data <= n_data;
            r_o_last <= n_last;
        end
    end

    // Control state: clock, sweep counter, valid flags, scan, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period   <= PERIOD_RESET;
            r_now      <= '0;
            r_sweep    <= '0;
            r_valid    <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_mask     <= '0;
            r_mark_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end

            // Start a new item: advance time on a tick, clear scan results
            if (i_cmd.load) begin
                r_cnt      <= '0;
                r_hit      <= 1'b0;
                r_mask     <= '0;
                r_mark_cnt <= '0;
                if (i_command == CMD_TICK) begin
                    r_now <= r_now + TIME_W'(1);
                    if (any_valid) begin
                        r_sweep <= o_stat.sweep_due ? '0 : sweep_inc;
                    end
                end
            end

            // Advance the scan address
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_step) begin
                r_cnt <= r_cnt + IDX_W'(1);
            end

            // Compare the slot read last cycle
            if (r_rd_vld && slot_valid) begin
                if ((r_rd_data.key == r_id) && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if ((r_cmd == CMD_TICK) && slot_late &&
                    (r_mark_cnt < MARK_W'(MAX_RESULTS))) begin
                    r_mask[r_rd_idx] <= 1'b1;
                    r_mark_cnt       <= r_mark_cnt + MARK_W'(1);
                end
            end

            // Finish add, response or cancel
            if (i_cmd.act) begin
                if (r_cmd == CMD_ADD) begin
                    if (add_ok) begin
                        r_valid[add_idx] <= 1'b1;
                    end
                end else if (r_cmd != CMD_TICK) begin
                    r_valid <= r_valid & ~hit_bit;
                    if ((r_valid & ~hit_bit) == '0) begin
                        r_sweep <= '0;
                    end
                end
            end

            // Free a reported slot
            if (i_cmd.emit) begin
                r_valid <= r_valid & ~emit_bit;
                r_mask  <= mask_rest;
            end

            // Output valid: set on load, drop on take
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_event_kind = r_o_kind;
    assign o_event_id   = r_o_id;
    assign o_event_tag  = r_o_tag;
    assign o_event_data = r_o_data;
    assign o_last       = r_o_last;

    // Marked slots are always live entries
    a_mask_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask & ~r_valid) == '0)
        else $error("timeout mark on a free slot");

    // A matched response or cancel frees its slot
    a_free_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.act && r_hit && (r_cmd == CMD_RESPONSE || r_cmd == CMD_CANCEL))
        |=> !r_valid[$past(r_hit_idx)])
        else $error("matched slot still valid after response or cancel");

    // A reported timeout is in the output register next cycle
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_valid && (o_event_kind == EV_TIMEOUT))
        else $error("timeout event not loaded");

endmodule

`default_nettype wire

[rtl/core/pending_ack_timeout_table.sv]
// ----------------------------------------------------------------------------
// pending_ack_timeout_table: table of outstanding acks with timeout sweeps
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) takes one item: add, response, cancel or
//   one millisecond tick. Output channel (o_valid/i_ready) returns events;
//   o_last marks the final event of an item. A tick that does not start a
//   sweep returns no event.
//   Each non-tick item scans all 16 slots through the single read port of the
//   entry memory, then loads its event into the output register once that
//   is free; the next item is taken after that. A tick without a sweep skips
//   the scan. A sweep tick also scans all 16 slots, then reads and loads its
//   timeouts one after another; the next item is taken after the last
//   timeout, or straight after the scan if none expired.
//   i_cfg_we writes check_period (ticks between sweeps) from i_cfg_wdata;
//   write it only while the block is idle.
//   Reset (i_rst_n low, synchronous) frees all slots, clears the clock and
//   sweep counter and sets check_period to 50. No clearing pass is needed.
//   When the receiver stalls, the event waits in the output register and
//   the sequencer holds before loading the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_ack_timeout_table import pat_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_command,
    input  wire logic [ID_W-1:0]     i_ack_id,
    input  wire logic [TMO_W-1:0]    i_timeout_ms,
    input  wire logic [TAG_W-1:0]    i_user_tag,
    input  wire logic [DATA_W-1:0]   i_response_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [KIND_W-1:0]        o_event_kind,
    output logic [ID_W-1:0]          o_event_id,
    output logic [TAG_W-1:0]         o_event_tag,
    output logic [DATA_W-1:0]        o_event_data,
    output logic                     o_last
);

    t_ctrl_cmd ctrl_cmd;
    t_dp_stat  dp_stat;

    // Sequencer
    pat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (dp_stat),
        .o_cmd   (ctrl_cmd)
    );

    // Datapath
    pat_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_command       (i_command),
        .i_ack_id        (i_ack_id),
        .i_timeout_ms    (i_timeout_ms),
        .i_user_tag      (i_user_tag),
        .i_response_data (i_response_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_kind    (o_event_kind),
        .o_event_id      (o_event_id),
        .o_event_tag     (o_event_tag),
        .o_event_data    (o_event_data),
        .o_last          (o_last),
        .i_cmd           (ctrl_cmd),
        .o_stat          (dp_stat)
    );

endmodule

`default_nettype wire

[verif/ack_table_check_pkg.sv]
// ----------------------------------------------------------------------------
// ack_table_check_pkg: event predictor and scoreboard for the ack table
// Keeps its own copy of the pending ack table, the millisecond clock and the
// sweep counter. Each accepted item is turned into the events it must cause,
// and each event from the block is compared field by field with the oldest.
// ----------------------------------------------------------------------------
package ack_table_check_pkg;

    import pat_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_ack_event;

    class ack_event_scoreboard;

        // Table copy and timing state
        logic [PERIOD_W-1:0] period;
        bit                  slot_live[TABLE_DEPTH];
        logic [ID_W-1:0]     slot_key[TABLE_DEPTH];
        logic [TIME_W-1:0]   slot_deadline[TABLE_DEPTH];
        logic [TAG_W-1:0]    slot_tag[TABLE_DEPTH];
        logic [TIME_W-1:0]   clock_ms;
        logic [PERIOD_W-1:0] sweep_ticks;

        // Events still owed by the block, oldest first
        t_ack_event  expected_events[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned kind_seen[8];

        function new();
            period      = PERIOD_RESET;
            clock_ms    = '0;
            sweep_ticks = '0;
            errors      = 0;
            checked     = 0;
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_period(input logic [PERIOD_W-1:0] value);
            period = value;
        endfunction

        function int find_slot(input logic [ID_W-1:0] id);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_live[i] && slot_key[i] == id) return i;
            end
            return -1;
        endfunction

        // Late only when strictly past the deadline, wrapping at 32 bits
        function bit overdue(input logic [TIME_W-1:0] deadline);
            logic [TIME_W-1:0] diff;
            diff = clock_ms - deadline;
            return (diff != '0) && !diff[TIME_W-1];
        endfunction

        function bit table_empty();
            foreach (slot_live[i]) begin
                if (slot_live[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function t_ack_event make_event(input logic [KIND_W-1:0] kind,
                                        input logic [ID_W-1:0] id,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [DATA_W-1:0] data);
            t_ack_event ev;
            ev.kind = kind;
            ev.id   = id;
            ev.tag  = tag;
            ev.data = data;
            ev.last = 1'b0;
            return ev;
        endfunction

        // Random key of a pending entry, or any key when the table is empty
        function logic [ID_W-1:0] live_key();
            int idx[$];
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (slot_live[i]) idx.push_back(i);
            end
            if (idx.size() == 0) return ID_W'($urandom);
            return slot_key[idx[$urandom_range(idx.size() - 1)]];
        endfunction

        // Apply one accepted item and queue the events it causes
        function void note_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [TMO_W-1:0] tmo, input logic [TAG_W-1:0] tag,
                                input logic [DATA_W-1:0] data);
            int         s;
            int         first;
            int         n;
            t_ack_event ev;
            first = expected_events.size();
            case (cmd)
                CMD_ADD: begin
                    // re-arm a pending id, else take the lowest free slot
                    s = find_slot(id);
                    if (s < 0) begin
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (!slot_live[i]) begin
                                s = i;
                                break;
                            end
                        end
                    end
                    if (s < 0) begin
                        expected_events.push_back(make_event(EV_FULL, id, '0, '0));
                    end else begin
                        slot_live[s]     = 1'b1;
                        slot_key[s]      = id;
                        slot_deadline[s] = clock_ms + TIME_W'(tmo);
                        slot_tag[s]      = tag;
                        expected_events.push_back(make_event(EV_ADDED, id, tag, '0));
                    end
                end
                CMD_RESPONSE, CMD_CANCEL: begin
                    s = find_slot(id);
                    if (s < 0) begin
                        expected_events.push_back(make_event(
                            (cmd == CMD_RESPONSE) ? EV_UNKNOWN : EV_CANCEL_UNKNOWN,
                            id, '0, '0));
                    end else begin
                        if (cmd == CMD_CANCEL) begin
                            ev = make_event(EV_CANCELLED, id, slot_tag[s], '0);
                        end else if (overdue(slot_deadline[s])) begin
                            ev = make_event(EV_LATE, id, slot_tag[s], '0);
                        end else begin
                            ev = make_event(EV_DELIVERED, id, slot_tag[s], data);
                        end
                        expected_events.push_back(ev);
                        slot_live[s] = 1'b0;
                    end
                    if (table_empty()) sweep_ticks = '0;
                end
                default: begin
                    // advance the clock; count toward a sweep only while busy
                    clock_ms = clock_ms + TIME_W'(1);
                    if (!table_empty()) begin
                        sweep_ticks = sweep_ticks + PERIOD_W'(1);
                        if (sweep_ticks >= period) begin
                            sweep_ticks = '0;
                            n = 0;
                            for (int i = 0; i < TABLE_DEPTH && n < MAX_RESULTS; i++) begin
                                if (slot_live[i] && overdue(slot_deadline[i])) begin
                                    expected_events.push_back(make_event(
                                        EV_TIMEOUT, slot_key[i], slot_tag[i], '0));
                                    slot_live[i] = 1'b0;
                                    n++;
                                end
                            end
                        end
                    end
                end
            endcase
            // flag the final event of this item
            if (expected_events.size() > first) begin
                ev = expected_events.pop_back();
                ev.last = 1'b1;
                expected_events.push_back(ev);
            end
        endfunction

        // Compare one event from the block with the oldest one owed
        function void check_event(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                  input logic [TAG_W-1:0] tag, input logic [DATA_W-1:0] data,
                                  input logic last);
            t_ack_event want;
            checked++;
            kind_seen[kind]++;
            if (expected_events.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("event %0d not expected: kind %0d id %h tag %h data %h last %0d",
                             checked, kind, id, tag, data, last);
                return;
            end
            want = expected_events.pop_front();
            if (want.kind !== kind || want.id !== id || want.tag !== tag ||
                want.data !== data || want.last !== last) begin
                errors++;
                if (errors <= 10) begin
                    $display("event %0d mismatch: expected kind %0d id %h tag %h data %h last %0d",
                             checked, want.kind, want.id, want.tag, want.data, want.last);
                    $display("                    actual kind %0d id %h tag %h data %h last %0d",
                             kind, id, tag, data, last);
                end
            end
        endfunction

    endclass

endpackage

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pending_ack_timeout_table
// Drives add, response, cancel and tick items through the valid/ready input,
// collects events from the output and checks each one against a predicted
// copy of the table. A directed opening is followed by random phases at
// several check periods and idling patterns on both channels.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pat_pkg::*;
    import ack_table_check_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS   = 52;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_we        = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wdata     = '0;
    logic                i_valid         = 1'b0;
    logic [1:0]          i_command       = CMD_TICK;
    logic [ID_W-1:0]     i_ack_id        = '0;
    logic [TMO_W-1:0]    i_timeout_ms    = '0;
    logic [TAG_W-1:0]    i_user_tag      = '0;
    logic [DATA_W-1:0]   i_response_data = '0;
    logic                i_ready         = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [KIND_W-1:0]   o_event_kind;
    logic [ID_W-1:0]     o_event_id;
    logic [TAG_W-1:0]    o_event_tag;
    logic [DATA_W-1:0]   o_event_data;
    logic                o_last;

    ack_event_scoreboard sb;
    int unsigned         send_idle_pct  = 0;
    int unsigned         recv_stall_pct = 0;
    int unsigned         items_sent     = 0;
    int unsigned         quiet_cycles   = 0;

    pending_ack_timeout_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_ack_id        (i_ack_id),
        .i_timeout_ms    (i_timeout_ms),
        .i_user_tag      (i_user_tag),
        .i_response_data (i_response_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_kind    (o_event_kind),
        .o_event_id      (o_event_id),
        .o_event_tag     (o_event_tag),
        .o_event_data    (o_event_data),
        .o_last          (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Check each accepted event, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_event(o_event_kind, o_event_id, o_event_tag, o_event_data, o_last);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d events still owed",
                     quiet_cycles, sb.expected_events.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Present one item after a random gap and hold it until accepted
    task automatic send_item(input logic [1:0] cmd, input logic [ID_W-1:0] id,
                             input logic [TMO_W-1:0] tmo, input logic [TAG_W-1:0] tag,
                             input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_ack_id        <= id;
        i_timeout_ms    <= tmo;
        i_user_tag      <= tag;
        i_response_data <= data;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_item(cmd, id, tmo, tag, data);
        items_sent++;
    endtask

    // Drop valid, drain every owed event, then let a silent sweep finish
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_period(value);
    endtask

    function automatic logic [TMO_W-1:0] pick_timeout();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return TMO_W'($urandom);
            default: return TMO_W'($urandom_range(24));
        endcase
    endfunction

    // Mostly well-formed traffic: fills, hits on pending ids and tick runs
    task automatic random_items(input int count);
        int unsigned      stop;
        int unsigned      pick;
        logic [ID_W-1:0]  id;
        stop = items_sent + count;
        while (items_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                repeat ($urandom_range(4, 17))
                    send_item(CMD_ADD, ID_W'($urandom), pick_timeout(), $urandom, $urandom);
            end else if (pick < 20) begin
                repeat ($urandom_range(1, 8))
                    send_item(CMD_TICK, ID_W'($urandom), TMO_W'($urandom), $urandom, $urandom);
            end else if (pick < 48) begin
                id = ($urandom_range(3) == 0) ? sb.live_key() : ID_W'($urandom);
                send_item(CMD_ADD, id, pick_timeout(), $urandom, $urandom);
            end else if (pick < 70) begin
                id = ($urandom_range(4) != 0) ? sb.live_key() : ID_W'($urandom);
                send_item(CMD_RESPONSE, id, TMO_W'($urandom), $urandom, $urandom);
            end else if (pick < 85) begin
                id = ($urandom_range(4) != 0) ? sb.live_key() : ID_W'($urandom);
                send_item(CMD_CANCEL, id, TMO_W'($urandom), $urandom, $urandom);
            end else begin
                send_item(CMD_TICK, ID_W'($urandom), TMO_W'($urandom), $urandom, $urandom);
            end
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0] periods[4];
        int unsigned         send_pcts[4];
        int unsigned         recv_pcts[4];
        sb        = new();
        periods   = '{PERIOD_W'(1), PERIOD_W'(0), PERIOD_W'(1023), PERIOD_W'(0)};
        send_pcts = '{0, 76, 0, 9};
        recv_pcts = '{0, 0, 76, 9};
        periods[3] = PERIOD_W'($urandom_range(2, 12));

        // Hold reset, then release
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening at the reset check period
        send_item(CMD_ADD, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, '0);
        send_item(CMD_ADD, 16'h0000, 16'hFFFF, 32'h0000_0000, '0);
        send_item(CMD_ADD, 16'hFFFF, 16'd2, 32'h5A5A_A5A5, '0);        // re-arm
        send_item(CMD_RESPONSE, 16'h0000, '0, '0, 32'hFFFF_FFFF);      // delivered
        send_item(CMD_RESPONSE, 16'h0000, '0, '0, 32'h0000_0001);      // unknown
        send_item(CMD_CANCEL, 16'h1234, '0, '0, '0);                   // cancel unknown
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_RESPONSE, 16'hFFFF, '0, '0, 32'h8000_0001);      // deadline now
        send_item(CMD_ADD, 16'h0001, 16'd0, 32'h0000_0001, '0);
        send_item(CMD_TICK, '0, '0, '0, '0);
        send_item(CMD_RESPONSE, 16'h0001, '0, '0, 32'h1234_5678);      // late
        send_item(CMD_ADD, 16'h0002, 16'd5, 32'h0000_0002, '0);
        send_item(CMD_CANCEL, 16'h0002, '0, '0, '0);                   // cancelled

        // Random phases, each at its own check period and idling pattern
        for (int p = 0; p < 4; p++) begin
            settle();
            write_period(periods[p]);
            send_idle_pct  = send_pcts[p];
            recv_stall_pct = recv_pcts[p];
            random_items(PHASE_ITEMS);
        end
        settle();

        $display("covered %0d items at check periods 50, 1, 0, 1023 and %0d, idle and busy",
                 items_sent, periods[3]);
        $display("checked %0d events: %0d timeouts, %0d table full, %0d late; %0d failures",
                 sb.checked, sb.kind_seen[EV_TIMEOUT], sb.kind_seen[EV_FULL],
                 sb.kind_seen[EV_LATE], sb.errors);
        if (sb.errors == 0 && sb.expected_events.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
